FILE: rtl/vehb_pkg.sv
// ----------------------------------------------------------------------------
// vehb_pkg
// Shared types, register indexes and helpers for the velocity breaker.
// ----------------------------------------------------------------------------
package vehb_pkg;

    // fixed-point widths
    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 17;
    localparam int CNT_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;

    // one in Q1.16
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1 << FRAC_W);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_HYSTERESIS = 2'd2;

    // configuration reset values
    localparam logic [WEIGHT_W-1:0] ALPHA_RST = 17'd6554;
    localparam logic [SAMPLE_W-1:0] MAXV_RST  = 32'd65536;
    localparam logic [WEIGHT_W-1:0] CLEAR_RST = 17'd52429;

    // front stage payload
    typedef struct packed {
        logic                seed;
        logic [SAMPLE_W-1:0] delta;
    } front_t;

    // weights above one act as one
    function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_W-1:0] w);
        logic [WEIGHT_W-1:0] r;
        r = (w > ONE_Q16) ? ONE_Q16 : w;
        return r;
    endfunction

endpackage

FILE: rtl/vehb_front.sv
// ----------------------------------------------------------------------------
// vehb_front
// Input stage: keeps the previous sample and forms the absolute difference.
// ----------------------------------------------------------------------------
module vehb_front
    import vehb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                cfg_clr,
    input  logic                in_valid,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                front_vld,
    output front_t              front
);

    logic                vld_reg;
    logic                seeded_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    front_t              front_reg;
    front_t              front_next;
    logic [SAMPLE_W:0]   diff;
    logic                xfer;

    assign xfer = in_valid && adv;

    // signed difference and its magnitude
    always_comb
    begin
        diff             = {sample[SAMPLE_W-1], sample} - {prev_reg[SAMPLE_W-1], prev_reg};
        front_next.seed  = !seeded_reg;
        front_next.delta = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    end

    // stage valid and seeding state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= 1'b0;
            seeded_reg <= 1'b0;
            prev_reg   <= '0;
        end
        else if (cfg_clr)
        begin
            seeded_reg <= 1'b0;
            prev_reg   <= '0;
        end
        else
        begin
            if (adv)
                vld_reg <= in_valid;
            if (xfer)
            begin
                seeded_reg <= 1'b1;
                prev_reg   <= sample;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
            front_reg <= front_next;
    end

    assign front_vld = vld_reg;
    assign front     = front_reg;

endmodule

FILE: rtl/vehb_ema.sv
// ----------------------------------------------------------------------------
// vehb_ema
// Exponential average: weighted difference product, then the average update.
// ----------------------------------------------------------------------------
module vehb_ema
    import vehb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                cfg_clr,
    input  logic [WEIGHT_W-1:0] alpha,
    input  logic                front_vld,
    input  front_t              front,
    output logic                avg_vld,
    output logic [SAMPLE_W-1:0] avg
);

    logic                mul_vld_reg;
    logic                mul_seed_reg;
    logic [PROD_W-1:0]   mul_reg;
    logic [PROD_W-1:0]   mul_next;
    logic                avg_vld_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] avg_next;
    logic [PROD_W-1:0]   acc;
    logic [WEIGHT_W-1:0] keep;

    // weighted newest difference
    assign mul_next = PROD_W'(alpha) * PROD_W'(front.delta);

    // blend with the running average
    always_comb
    begin
        keep     = ONE_Q16 - alpha;
        acc      = mul_reg + PROD_W'(keep) * PROD_W'(avg_reg);
        avg_next = acc[FRAC_W+SAMPLE_W-1:FRAC_W];
    end

    // stage valids and average state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            avg_vld_reg <= 1'b0;
            avg_reg     <= '0;
        end
        else if (cfg_clr)
        begin
            avg_reg <= '0;
        end
        else if (adv)
        begin
            mul_vld_reg <= front_vld;
            avg_vld_reg <= mul_vld_reg;
            if (mul_vld_reg && !mul_seed_reg)
                avg_reg <= avg_next;
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_reg      <= mul_next;
            mul_seed_reg <= front.seed;
        end
    end

    assign avg_vld = avg_vld_reg;
    assign avg     = avg_reg;

endmodule

FILE: rtl/vehb_trip.sv
// ----------------------------------------------------------------------------
// vehb_trip
// Hysteresis breaker, event pulses, saturating counters and result register.
// ----------------------------------------------------------------------------
module vehb_trip
    import vehb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                cfg_clr,
    input  logic [SAMPLE_W-1:0] max_vel,
    input  logic [PROD_W-1:0]   clear_lvl,
    input  logic                avg_vld,
    input  logic [SAMPLE_W-1:0] avg,
    output logic                out_valid,
    output logic                tripped,
    output logic                trip_event,
    output logic                clear_event,
    output logic [SAMPLE_W-1:0] velocity,
    output logic [CNT_W-1:0]    trip_total,
    output logic [CNT_W-1:0]    sample_total
);

    logic                out_vld_reg;
    logic                trip_reg;
    logic                trip_ev_reg;
    logic                clear_ev_reg;
    logic [SAMPLE_W-1:0] vel_reg;
    logic [CNT_W-1:0]    trip_cnt_reg;
    logic [CNT_W-1:0]    smp_cnt_reg;
    logic                trip_next;
    logic                step;

    assign step = avg_vld && adv;

    // hold level once tripped, strict threshold otherwise
    always_comb
    begin
        if (trip_reg)
            trip_next = {1'b0, avg, {FRAC_W{1'b0}}} >= clear_lvl;
        else
            trip_next = avg > max_vel;
    end

    // breaker state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            trip_reg     <= 1'b0;
            trip_cnt_reg <= '0;
            smp_cnt_reg  <= '0;
        end
        else if (cfg_clr)
        begin
            trip_reg     <= 1'b0;
            trip_cnt_reg <= '0;
            smp_cnt_reg  <= '0;
        end
        else
        begin
            if (adv)
                out_vld_reg <= avg_vld;
            if (step)
            begin
                trip_reg <= trip_next;
                if (~&smp_cnt_reg)
                    smp_cnt_reg <= smp_cnt_reg + CNT_W'(1);
                if (trip_next && !trip_reg && ~&trip_cnt_reg)
                    trip_cnt_reg <= trip_cnt_reg + CNT_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trip_ev_reg  <= trip_next && !trip_reg;
            clear_ev_reg <= !trip_next && trip_reg;
            vel_reg      <= avg;
        end
    end

    assign out_valid    = out_vld_reg;
    assign tripped      = trip_reg;
    assign trip_event   = trip_ev_reg;
    assign clear_event  = clear_ev_reg;
    assign velocity     = vel_reg;
    assign trip_total   = trip_cnt_reg;
    assign sample_total = smp_cnt_reg;

`ifndef SYNTH
    // a trip pulse always shows the breaker tripped
    a_trip_ev_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && trip_ev_reg |-> trip_reg)
        else $error("trip event without tripped level");

    // a clear pulse always shows the breaker clear
    a_clear_ev_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && clear_ev_reg |-> !trip_reg)
        else $error("clear event with tripped level");

    // every trip comes with a counted sample
    a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
        trip_cnt_reg <= smp_cnt_reg)
        else $error("trip count above sample count");

    // from clear, an average above the threshold trips the breaker at that transfer
    a_trip_on_excess: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg_clr && !trip_reg && (avg > max_vel) |=> trip_reg && trip_ev_reg)
        else $error("average above threshold did not trip");
`endif

endmodule

FILE: rtl/velocity_ema_hysteresis_breaker.sv
// ----------------------------------------------------------------------------
// velocity_ema_hysteresis_breaker
// Rate-of-change breaker: exponential average of sample differences with a
// hysteresis trip flag and saturating counters.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | in_valid / in_stall     | sample
//  output   | out_valid / out_stall   | tripped, trip_event, clear_event,
//           |                         | velocity, trip_total, sample_total
//  config   | cfg_wr_en               | cfg_index, cfg_data
//
//  One sample per cycle while no result is stalled; a result passes through
//  four register stages (difference, loaded at the transfer edge,
//  weighted product, average update, breaker and counters).
//  The average update is the only loop with a multiply: one 17x32 multiply and an add.
//  A stalled result freezes the whole pipeline; in_stall follows it.
//  Reset or a known write clears seed, average, breaker and counters at once.
// ----------------------------------------------------------------------------
module velocity_ema_hysteresis_breaker
    import vehb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 tripped,
    output logic                 trip_event,
    output logic                 clear_event,
    output logic [SAMPLE_W-1:0]  velocity,
    output logic [CNT_W-1:0]     trip_total,
    output logic [CNT_W-1:0]     sample_total
);

    logic [WEIGHT_W-1:0] alpha_reg;
    logic [SAMPLE_W-1:0] maxv_reg;
    logic [WEIGHT_W-1:0] clear_reg;
    logic [PROD_W-1:0]   clear_lvl_reg;
    logic                cfg_clr;
    logic                adv;
    logic                front_vld;
    front_t              front;
    logic                avg_vld;
    logic [SAMPLE_W-1:0] avg;

    // pipeline moves unless a finished result is held
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // known register writes clear seeding, average, breaker and counters
    always_comb
    begin
        cfg_clr = cfg_wr_en && (cfg_index inside {CFG_EMA_ALPHA, CFG_MAX_VELOCITY,
                                                  CFG_CLEAR_HYSTERESIS});
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            maxv_reg  <= MAXV_RST;
            clear_reg <= CLEAR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_EMA_ALPHA:        alpha_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_MAX_VELOCITY:     maxv_reg  <= cfg_data;
                CFG_CLEAR_HYSTERESIS: clear_reg <= cfg_data[WEIGHT_W-1:0];
                default:              ;
            endcase
        end
    end

    // clear level = threshold times clear factor, refreshed every cycle
    always_ff @(posedge clk)
    begin
        clear_lvl_reg <= PROD_W'(maxv_reg) * PROD_W'(clamp_weight(clear_reg));
    end

    vehb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg_clr   (cfg_clr),
        .in_valid  (in_valid),
        .sample    (sample),
        .front_vld (front_vld),
        .front     (front)
    );

    vehb_ema u_ema (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg_clr   (cfg_clr),
        .alpha     (clamp_weight(alpha_reg)),
        .front_vld (front_vld),
        .front     (front),
        .avg_vld   (avg_vld),
        .avg       (avg)
    );

    vehb_trip u_trip (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cfg_clr      (cfg_clr),
        .max_vel      (maxv_reg),
        .clear_lvl    (clear_lvl_reg),
        .avg_vld      (avg_vld),
        .avg          (avg),
        .out_valid    (out_valid),
        .tripped      (tripped),
        .trip_event   (trip_event),
        .clear_event  (clear_event),
        .velocity     (velocity),
        .trip_total   (trip_total),
        .sample_total (sample_total)
    );

endmodule

FILE: bench/breaker_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// breaker_scoreboard_pkg
// Bit-exact prediction of the velocity breaker and an in-order result check.
// Each sample transfer queues one expected result. Each result transfer is
// compared field by field with the oldest one.
// ----------------------------------------------------------------------------
package breaker_scoreboard_pkg;

    import vehb_pkg::*;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one result transfer
    typedef struct packed {
        logic                tripped;
        logic                trip_event;
        logic                clear_event;
        logic [SAMPLE_W-1:0] velocity;
        logic [CNT_W-1:0]    trip_total;
        logic [CNT_W-1:0]    sample_total;
    } breaker_out_t;

    class breaker_scoreboard;

        // register copies
        logic [WEIGHT_W-1:0] alpha;
        logic [SAMPLE_W-1:0] max_vel;
        logic [WEIGHT_W-1:0] clear_frac;

        // breaker state
        logic [SAMPLE_W-1:0] last_sample;
        logic [SAMPLE_W-1:0] avg_vel;
        logic                seeded;
        logic                trip_flag;
        logic [CNT_W-1:0]    trip_cnt;
        logic [CNT_W-1:0]    sample_cnt;

        // results still on their way out of the block
        breaker_out_t        awaited[$];

        int                  mismatches;
        int                  checked;
        int                  trips_seen;
        int                  clears_seen;
        int                  settings;

        function new();
            alpha       = ALPHA_RST;
            max_vel     = MAXV_RST;
            clear_frac  = CLEAR_RST;
            mismatches  = 0;
            checked     = 0;
            trips_seen  = 0;
            clears_seen = 0;
            settings    = 0;
            clear_state();
        endfunction

        function void clear_state();
            last_sample = '0;
            avg_vel     = '0;
            seeded      = 1'b0;
            trip_flag   = 1'b0;
            trip_cnt    = '0;
            sample_cnt  = '0;
        endfunction

        // weights above one act as one
        function logic [63:0] as_weight(logic [WEIGHT_W-1:0] w);
            as_weight = (w > ONE_Q16) ? 64'(ONE_Q16) : 64'(w);
        endfunction

        // register write: known indexes store and clear the state
        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
            settings++;
            case (idx)
                CFG_EMA_ALPHA:        alpha      = data[WEIGHT_W-1:0];
                CFG_MAX_VELOCITY:     max_vel    = data;
                CFG_CLEAR_HYSTERESIS: clear_frac = data[WEIGHT_W-1:0];
                default:              return;
            endcase
            clear_state();
        endfunction

        // accepted sample: advance the breaker and queue its result
        function void note_sample(logic [SAMPLE_W-1:0] s);
            breaker_out_t        r;
            logic signed [SAMPLE_W:0] diff;
            logic [SAMPLE_W:0]   mag;
            logic [63:0]         a;
            logic [63:0]         acc;
            logic                was_tripped;
            logic                trip_now;
            was_tripped = trip_flag;
            if (sample_cnt != '1)
                sample_cnt = sample_cnt + CNT_W'(1);

            // first sample only seeds the stored value
            if (!seeded) begin
                last_sample = s;
                seeded      = 1'b1;
            end
            else begin
                diff    = $signed({s[SAMPLE_W-1], s})
                        - $signed({last_sample[SAMPLE_W-1], last_sample});
                mag     = diff[SAMPLE_W] ? -diff : diff;
                a       = as_weight(alpha);
                acc     = a * 64'(mag[SAMPLE_W-1:0]) + (64'(ONE_Q16) - a) * 64'(avg_vel);
                avg_vel = acc[FRAC_W +: SAMPLE_W];
                last_sample = s;
            end

            // hysteresis: exact compare against threshold times clear factor
            if (was_tripped)
                trip_now = (64'(avg_vel) << FRAC_W) >= (64'(max_vel) * as_weight(clear_frac));
            else
                trip_now = avg_vel > max_vel;

            r.trip_event  = trip_now && !was_tripped;
            r.clear_event = !trip_now && was_tripped;
            if (r.trip_event && trip_cnt != '1)
                trip_cnt = trip_cnt + CNT_W'(1);
            trip_flag = trip_now;

            r.tripped      = trip_now;
            r.velocity     = avg_vel;
            r.trip_total   = trip_cnt;
            r.sample_total = sample_cnt;
            awaited.push_back(r);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void flag_field(string field, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %0h, got %0h",
                         $time, field, want, got);
        endfunction

        // result transfer: compare with the oldest expectation
        function void check_result(breaker_out_t got);
            breaker_out_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with nothing expected: velocity %0h",
                             $time, got.velocity);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.trip_event)
                trips_seen++;
            if (want.clear_event)
                clears_seen++;
            if (got.tripped !== want.tripped)
                flag_field("tripped", 64'(want.tripped), 64'(got.tripped));
            if (got.trip_event !== want.trip_event)
                flag_field("trip_event", 64'(want.trip_event), 64'(got.trip_event));
            if (got.clear_event !== want.clear_event)
                flag_field("clear_event", 64'(want.clear_event), 64'(got.clear_event));
            if (got.velocity !== want.velocity)
                flag_field("velocity", 64'(want.velocity), 64'(got.velocity));
            if (got.trip_total !== want.trip_total)
                flag_field("trip_total", 64'(want.trip_total), 64'(got.trip_total));
            if (got.sample_total !== want.sample_total)
                flag_field("sample_total", 64'(want.sample_total), 64'(got.sample_total));
        endfunction

    endclass

endpackage

FILE: bench/tb_velocity_ema_hysteresis_breaker.sv
// ----------------------------------------------------------------------------
// tb_velocity_ema_hysteresis_breaker
// Self-checking bench for the velocity breaker. A short directed sequence
// hits seeding, extreme samples, weight clamping, exact hysteresis edges and
// register writes; shaped random walks then drive the breaker through trip
// and clear cycles under assorted settings, with random idling on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_velocity_ema_hysteresis_breaker;

    timeunit 1ns;
    timeprecision 1ps;

    import vehb_pkg::*;
    import breaker_scoreboard_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    typedef enum {WALK_NOISE, WALK_CALM, WALK_HOT} walk_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  sample;
    logic                 out_valid;
    logic                 out_stall;
    logic                 tripped;
    logic                 trip_event;
    logic                 clear_event;
    logic [SAMPLE_W-1:0]  velocity;
    logic [CNT_W-1:0]     trip_total;
    logic [CNT_W-1:0]     sample_total;

    breaker_scoreboard    tracker;
    breaker_out_t         observed;
    bit                   steady;
    int                   hold_len;
    int                   quiet_cycles;
    int                   sent;

    velocity_ema_hysteresis_breaker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tripped      (tripped),
        .trip_event   (trip_event),
        .clear_event  (clear_event),
        .velocity     (velocity),
        .trip_total   (trip_total),
        .sample_total (sample_total)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                n        = hold_len;
                hold_len = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= !steady && ($urandom_range(0, 99) < 28);
        end
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.tripped      = tripped;
            observed.trip_event   = trip_event;
            observed.clear_event  = clear_event;
            observed.velocity     = velocity;
            observed.trip_total   = trip_total;
            observed.sample_total = sample_total;
            tracker.check_result(observed);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one sample transfer, with random idle cycles ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_sample(s);
        sent++;
    endtask

    // stop offering and wait until every expected result is out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // register write; back-to-back writes keep the enable high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.apply_write(idx, data);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
    endtask

    // random but sensible settings; threshold doubles as the walk scale
    task automatic pick_config(output logic [SAMPLE_W-1:0] scale);
        scale = $urandom_range(32'h100, 32'h100_0000);
        write_reg(CFG_EMA_ALPHA, $urandom_range(1500, 40000));
        write_reg(CFG_MAX_VELOCITY, scale);
        write_reg(CFG_CLEAR_HYSTERESIS, $urandom_range(0, 65536));
        end_writes();
    endtask

    // random walk in bursts: hot bursts push the average over the threshold,
    // calm ones let it decay, a few noise bursts jump anywhere
    task automatic walk(input int count, input logic [SAMPLE_W-1:0] scale);
        int                  left;
        int                  run;
        walk_mode_t          mode;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] step;
        left  = count;
        level = $urandom();
        while (left > 0)
        begin
            run  = $urandom_range(8, 30);
            mode = walk_mode_t'($urandom_range(0, 9) == 0 ? WALK_NOISE :
                               ($urandom_range(0, 1) ? WALK_CALM : WALK_HOT));
            if (run > left)
                run = left;
            left -= run;
            repeat (run)
            begin
                if (mode == WALK_NOISE)
                    level = $urandom();
                else
                begin
                    if (mode == WALK_CALM)
                        step = $urandom_range(0, scale / 4);
                    else
                        step = scale + $urandom_range(0, 2 * scale);
                    level = $urandom_range(0, 1) ? level + step : level - step;
                end
                send_sample(level);
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [SAMPLE_W-1:0] scale;
        tracker      = new();
        steady       = 1'b0;
        hold_len     = 0;
        sent         = 0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: seeding, then the largest jumps both ways
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        drain();

        // weights above one, masked data; exact trip and clear edges
        write_reg(CFG_EMA_ALPHA, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_VELOCITY, 32'h0001_0000);
        write_reg(CFG_CLEAR_HYSTERESIS, 32'h0001_FFFF);
        end_writes();
        send_sample(32'h0005_0000);
        send_sample(32'h0007_0000);
        send_sample(32'h0008_0000);
        send_sample(32'h0008_FFFF);
        send_sample(32'h0009_FFFF);
        send_sample(32'h000B_0000);
        drain();

        // write to an unused index leaves the state alone
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        end_writes();
        send_sample(32'h000B_0000);
        drain();

        // zero threshold and zero clear factor: once tripped, stays tripped
        write_reg(CFG_EMA_ALPHA, 32'h0001_0000);
        write_reg(CFG_MAX_VELOCITY, 32'h0000_0000);
        write_reg(CFG_CLEAR_HYSTERESIS, 32'h0000_0000);
        end_writes();
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h0000_0001);
        send_sample(32'h8000_0000);
        drain();

        // zero weight: the average never moves
        write_reg(CFG_EMA_ALPHA, 32'h0000_0000);
        end_writes();
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h1234_5678);
        drain();

        // random walks under assorted settings
        for (int p = 0; p < 6; p++)
        begin
            pick_config(scale);
            steady = (p == 2);
            if (p == 4)
                hold_len = HOLD_CYCLES;
            walk(60, scale);
            drain();
            if (p == 3)
            begin
                write_reg(CFG_UNUSED, $urandom());
                end_writes();
                walk(30, scale);
                drain();
            end
        end
        steady = 1'b0;

        // fully random register data, weights often clamped
        write_reg(CFG_EMA_ALPHA, $urandom());
        write_reg(CFG_MAX_VELOCITY, $urandom());
        write_reg(CFG_CLEAR_HYSTERESIS, $urandom());
        end_writes();
        walk(40, 32'h0100_0000);
        drain();

        // largest threshold with full weight and arbitrary samples
        write_reg(CFG_EMA_ALPHA, 32'(ONE_Q16));
        write_reg(CFG_MAX_VELOCITY, 32'hFFFF_FFFF);
        end_writes();
        repeat (20) send_sample($urandom());
        drain();

        // let any stray result show up
        repeat (8) @(posedge clk);

        $display("run covered %0d samples, %0d results checked, %0d register writes",
                 sent, tracker.checked, tracker.settings);
        $display("breaker tripped %0d times and cleared %0d times",
                 tracker.trips_seen, tracker.clears_seen);
        if (tracker.pending() != 0)
            $display("%0d expected results never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
